// ===== sv/smvlq_pkg.sv =====
package smvlq_pkg;

    localparam int DIGIT_BITS = 5;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [1:0] LAST_NUM = 2'd3;

    typedef struct packed {
        logic start_seg;
        logic start_semi;
        logic clear_start;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic at_line_start;
        logic last;
    } stat_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ===== sv/source_map_vlq_segment_encoder_core.sv =====
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: file, line, column; s_tuser: opcode
// m_       out  m_tvalid / m_tready       m_tdata: char; m_tlast: last char of the event
// apb      in   psel / penable / pready   reg 0 at 0x0: enable
//
// one event at a time; an input beat is taken only while no character is pending
// a line-start location gives 4 to 14 characters, one per cycle while m_tready is high, set by the
// digit sequencer that walks four numbers (a zero, then the three folded ones) 5 bits at a time
// end of line gives one ';' beat, other locations none
// aresetn is synchronous, active low; m_tready low holds the current character
module source_map_vlq_segment_encoder_core
    import smvlq_pkg::*;
#(
    parameter int FILE_BITS = 16,
    parameter int LINE_BITS = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // file_index[15:0], line_number[39:16], column_number[55:40]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t  cmd;
    stat_t stat;
    logic  enable;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, enable};

    smvlq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smvlq_dp #(
        .FILE_BITS   (FILE_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .file_index    (s_tdata[15:0]),
        .line_number   (s_tdata[39:16]),
        .column_number (s_tdata[55:40]),
        .cfg_wr        (cfg_wr),
        .cfg_data      (pwdata[0]),
        .enable        (enable),
        .out_char      (m_tdata),
        .last_char     (m_tlast)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a character is pending");

    a_semi_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata == CHAR_SEMI)) |-> m_tlast)
        else $error("semicolon beat not marked last");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after last character");

    a_eol_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser && enable) |=> (m_tvalid && m_tlast))
        else $error("end of line gave no semicolon");

endmodule

// ===== sv/smvlq_ctrl.sv =====
module smvlq_ctrl
    import smvlq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  s_tuser,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic in_beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign in_beat  = s_tvalid && s_tready && stat.enable;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_tuser) begin
                        cmd.start_semi = 1'b1;
                        state_next = ST_EMIT;
                    end else if (stat.at_line_start) begin
                        cmd.start_seg = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.clear_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/smvlq_dp.sv =====
module smvlq_dp
    import smvlq_pkg::*;
#(
    parameter int FILE_BITS = 16,
    parameter int LINE_BITS = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [15:0] file_index,
    input  logic [23:0] line_number,
    input  logic [15:0] column_number,
    input  logic        cfg_wr,
    input  logic        cfg_data,
    output logic        enable,
    output logic [7:0]  out_char,
    output logic        last_char
);

    localparam int MAXB_FL = (FILE_BITS > LINE_BITS) ? FILE_BITS : LINE_BITS;
    localparam int MAXB = (MAXB_FL > COLUMN_BITS) ? MAXB_FL : COLUMN_BITS;
    localparam int W = MAXB + 1;

    logic                  enable_reg;
    logic                  at_start_reg;
    logic                  semi_reg;
    logic [1:0]            num_reg;
    logic [W-1:0]          cur_reg;
    logic [W-1:0]          fold_reg [0:2];
    logic [FILE_BITS-1:0]  prev_file_reg;
    logic [LINE_BITS-1:0]  prev_line_reg;
    logic [COLUMN_BITS-1:0] prev_col_reg;

    logic [FILE_BITS-1:0]  f_val;
    logic [LINE_BITS-1:0]  l_val;
    logic [COLUMN_BITS-1:0] c_val;
    logic [31:0]           line_m1;
    logic [W-1:0]          fold_f;
    logic [W-1:0]          fold_l;
    logic [W-1:0]          fold_c;
    logic [W-1:0]          cur_shift;
    logic                  more;
    logic [4:0]            digit;

    function automatic logic [W-1:0] fold(input logic [MAXB-1:0] c,
                                          input logic [MAXB-1:0] p);
        logic            ge;
        logic [MAXB-1:0] mag;
        ge = (c >= p);
        mag = ge ? (c - p) : (p - c);
        return {mag, ~ge};
    endfunction

    assign f_val   = FILE_BITS'(32'(file_index));
    assign line_m1 = 32'(line_number) - 32'd1;
    assign l_val   = LINE_BITS'(line_m1);
    assign c_val   = COLUMN_BITS'(32'(column_number));

    assign fold_f = fold(MAXB'(f_val), MAXB'(prev_file_reg));
    assign fold_l = fold(MAXB'(l_val), MAXB'(prev_line_reg));
    assign fold_c = fold(MAXB'(c_val), MAXB'(prev_col_reg));

    assign cur_shift = cur_reg >> DIGIT_BITS;
    assign more      = |cur_shift;
    assign digit     = 5'(cur_reg);

    assign out_char  = semi_reg ? CHAR_SEMI : b64_char({more, digit});
    assign last_char = semi_reg || (!more && (num_reg == LAST_NUM));

    assign enable             = enable_reg;
    assign stat.enable        = enable_reg;
    assign stat.at_line_start = at_start_reg;
    assign stat.last          = last_char;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            at_start_reg  <= 1'b1;
            prev_file_reg <= '0;
            prev_line_reg <= '0;
            prev_col_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                enable_reg <= cfg_data;
            end
            if (cmd.start_semi) begin
                at_start_reg <= 1'b1;
            end else if (cmd.start_seg || cmd.clear_start) begin
                at_start_reg <= 1'b0;
            end
            if (cmd.start_seg) begin
                prev_file_reg <= f_val;
                prev_line_reg <= l_val;
                prev_col_reg  <= c_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_seg) begin
            semi_reg    <= 1'b0;
            num_reg     <= 2'd0;
            cur_reg     <= '0;
            fold_reg[0] <= fold_f;
            fold_reg[1] <= fold_l;
            fold_reg[2] <= fold_c;
        end else if (cmd.start_semi) begin
            semi_reg <= 1'b1;
        end else if (cmd.advance) begin
            if (more) begin
                cur_reg <= cur_shift;
            end else begin
                num_reg     <= num_reg + 2'd1;
                cur_reg     <= fold_reg[0];
                fold_reg[0] <= fold_reg[1];
                fold_reg[1] <= fold_reg[2];
            end
        end
    end

endmodule
